FILE: design/eco_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eco_pkg: shared types and constants
// Angle constants, CORDIC table and controller states for the camera unit.
// ----------------------------------------------------------------------------
package eco_pkg;

  localparam int AngHalf   = 46080;
  localparam int AngFull   = 92160;
  localparam int AngQuart  = 23040;
  localparam int PitchLim  = 22784;
  localparam int CordicN   = 16;
  localparam logic signed [33:0] CordicK = 34'sd652032874;
  localparam logic signed [33:0] OneQ30  = 34'sd1073741824;
  localparam logic [15:0] SensReset = 16'd410;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_PREP,
    ST_ROT,
    ST_MUL,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic upd;     // latch item, update angles
    logic wrap;    // wrap yaw, reduce pitch for trig
    logic prep;    // load CORDIC for current angle
    logic rot;     // one CORDIC iteration
    logic fin;     // store sin/cos of current angle
    logic mul;     // one product step
    logic pack;    // register result
  } cmd_t;

  typedef struct packed {
    logic rot_last;
    logic sel_pitch;  // current CORDIC angle is pitch
    logic mul_last;
  } sts_t;

  function automatic logic signed [23:0] atan_q16(input logic [3:0] i);
    logic signed [23:0] r;
    case (i)
      4'd0:  r = 24'sd2949120;
      4'd1:  r = 24'sd1740967;
      4'd2:  r = 24'sd919879;
      4'd3:  r = 24'sd466945;
      4'd4:  r = 24'sd234379;
      4'd5:  r = 24'sd117304;
      4'd6:  r = 24'sd58666;
      4'd7:  r = 24'sd29335;
      4'd8:  r = 24'sd14668;
      4'd9:  r = 24'sd7334;
      4'd10: r = 24'sd3667;
      4'd11: r = 24'sd1833;
      4'd12: r = 24'sd917;
      4'd13: r = 24'sd458;
      4'd14: r = 24'sd229;
      default: r = 24'sd115;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: design/eco_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eco_ctrl: sequencer
// Steps the datapath through update, two CORDIC runs, products and output.
// ----------------------------------------------------------------------------
module eco_ctrl import eco_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  wire  out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   ov_q, ov_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o = ov_q;

  always_comb begin
    state_d    = state_q;
    ov_d       = ov_q & ~out_ready_i;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.upd = 1'b1;
          state_d   = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd_o.wrap = 1'b1;
        state_d    = ST_PREP;
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_ROT;
      end
      ST_ROT: begin
        cmd_o.rot = 1'b1;
        if (sts_i.rot_last) begin
          cmd_o.fin = 1'b1;
          state_d   = sts_i.sel_pitch ? ST_MUL : ST_PREP;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        if (sts_i.mul_last) state_d = ST_OUT;
      end
      ST_OUT: begin
        // output register free or being drained this cycle
        if (!ov_q || out_ready_i) begin
          cmd_o.pack = 1'b1;
          ov_d       = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: design/eco_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eco_dp: datapath
// Angle update, shared CORDIC, shared multiplier and output registers.
// ----------------------------------------------------------------------------
module eco_dp import eco_pkg::*; (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire         [15:0] cfg_wdata_i,
  input  wire  signed [15:0] delta_x_i,
  input  wire  signed [15:0] delta_y_i,
  input  wire                limit_pitch_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  output logic signed [15:0] front_x_o,
  output logic signed [15:0] front_y_o,
  output logic signed [15:0] front_z_o,
  output logic signed [15:0] right_x_o,
  output logic signed [15:0] right_y_o,
  output logic signed [15:0] right_z_o,
  output logic signed [15:0] up_x_o,
  output logic signed [15:0] up_y_o,
  output logic signed [15:0] up_z_o,
  output logic signed [16:0] yaw_out_o,
  output logic signed [23:0] pitch_out_o,
  output logic               degenerate_o
);

  logic        [15:0] sens_q;
  logic signed [23:0] yaw_q, pitch_q;
  logic signed [25:0] ys_q;
  logic signed [16:0] rp_q;

  // ---- angle update (one multiply each, two in parallel of 16x17)
  logic signed [32:0] px, py;
  logic signed [24:0] inc_x, inc_y;
  logic signed [25:0] ys_d, ps;
  logic signed [23:0] pitch_d;

  // wrap by constant: |v| < 2^25, so quotient via reciprocal multiply
  function automatic logic signed [16:0] wrap26(input logic signed [25:0] v);
    logic signed [26:0] t;
    logic signed [45:0] m;
    logic signed [26:0] q;
    logic signed [27:0] r;
    t = 27'(v) + 27'(AngHalf);
    // floor(t/92160) approx with 2^31/92160 = 23301.6
    m = t * $signed(19'sd23302);
    q = 27'(m >>> 31);
    r = 28'(t) - 28'(q) * 28'(AngFull);
    if (r < 0) r = r + 28'(AngFull);
    if (r >= 28'(AngFull)) r = r - 28'(AngFull);
    return 17'(r - 28'(AngHalf));
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q  <= SensReset;
      yaw_q   <= -24'(AngQuart);
      pitch_q <= '0;
      ys_q    <= -26'(AngQuart);
    end else begin
      if (cfg_we_i) sens_q <= cfg_wdata_i;
      if (cmd_i.upd) begin
        ys_q    <= ys_d;
        pitch_q <= pitch_d;
      end
      // raw yaw sum folded back to [-180,180) in the cycle after the update
      if (cmd_i.wrap) yaw_q <= 24'(wrap26(ys_q));
    end
  end

  always_comb begin
    px    = delta_x_i * $signed({1'b0, sens_q}) + 33'sd128;
    py    = delta_y_i * $signed({1'b0, sens_q}) + 33'sd128;
    inc_x = px[32:8];
    inc_y = py[32:8];
    // yaw in [-46080,46079], inc within about +-2^23
    ys_d = 26'(yaw_q) + 26'(inc_x);
    ps   = 26'(pitch_q) + 26'(inc_y);
    if (ps > 26'sd8388607) ps = 26'sd8388607;
    if (ps < -26'sd8388608) ps = -26'sd8388608;
    if (limit_pitch_i) begin
      if (ps > 26'(PitchLim)) ps = 26'(PitchLim);
      if (ps < -26'(PitchLim)) ps = -26'(PitchLim);
    end
    pitch_d = ps[23:0];
  end

  // reduced pitch for trig
  always_ff @(posedge clk_i) begin
    if (cmd_i.wrap) rp_q <= wrap26(26'(pitch_q));
  end

  // ---- CORDIC, shared between yaw and pitch
  logic               sel_q;
  logic [3:0]         it_q;
  logic signed [33:0] cx_q, cy_q;
  logic signed [25:0] cz_q;
  logic               neg_q, spec_q;
  logic signed [33:0] spec_s_q, spec_c_q;
  logic signed [33:0] sy_q, cy2_q, sp_q, cp_q;

  logic signed [16:0] a_cur, a_fold;
  logic               a_neg, a_spec;
  logic signed [33:0] a_s, a_c;
  always_comb begin
    a_cur  = sel_q ? rp_q : yaw_q[16:0];
    a_neg  = 1'b0;
    a_fold = a_cur;
    a_spec = 1'b1;
    a_s    = '0;
    a_c    = '0;
    if (a_cur == 17'sd0) a_c = OneQ30;
    else if (a_cur == 17'(AngQuart)) a_s = OneQ30;
    else if (a_cur == -17'(AngQuart)) a_s = -OneQ30;
    else if (a_cur == -17'(AngHalf)) a_c = -OneQ30;
    else a_spec = 1'b0;
    if (a_cur > 17'(AngQuart)) begin
      a_fold = a_cur - 17'(AngHalf);
      a_neg  = 1'b1;
    end else if (a_cur < -17'(AngQuart)) begin
      a_fold = a_cur + 17'(AngHalf);
      a_neg  = 1'b1;
    end
  end

  logic signed [33:0] dx, dy;
  assign dx = cy_q >>> it_q;
  assign dy = cx_q >>> it_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
      it_q  <= '0;
    end else begin
      if (cmd_i.upd) sel_q <= 1'b0;
      else if (cmd_i.fin) sel_q <= 1'b1;
      if (cmd_i.prep) it_q <= '0;
      else if (cmd_i.rot) it_q <= it_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      cx_q     <= CordicK;
      cy_q     <= '0;
      cz_q     <= 26'(a_fold) <<< 8;
      neg_q    <= a_neg;
      spec_q   <= a_spec;
      spec_s_q <= a_s;
      spec_c_q <= a_c;
    end else if (cmd_i.rot) begin
      if (!cz_q[25]) begin
        cx_q <= cx_q - dx;
        cy_q <= cy_q + dy;
        cz_q <= cz_q - 26'(atan_q16(it_q));
      end else begin
        cx_q <= cx_q + dx;
        cy_q <= cy_q - dy;
        cz_q <= cz_q + 26'(atan_q16(it_q));
      end
    end
  end

  // final values include the last iteration
  logic signed [33:0] fx, fy, fs, fc;
  always_comb begin
    if (!cz_q[25]) begin
      fx = cx_q - dx;
      fy = cy_q + dy;
    end else begin
      fx = cx_q + dx;
      fy = cy_q - dy;
    end
    if (spec_q) begin
      fs = spec_s_q;
      fc = spec_c_q;
    end else begin
      fs = neg_q ? -fy : fy;
      fc = neg_q ? -fx : fx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      if (sel_q) begin
        sp_q <= fs;
        cp_q <= fc;
      end else begin
        sy_q  <= fs;
        cy2_q <= fc;
      end
    end
  end

  // ---- products: one 32x32 multiply per step, four steps
  logic [1:0]         mi_q;
  logic signed [65:0] pr_q [4];
  logic signed [31:0] ma, mb;
  always_comb begin
    case (mi_q)
      2'd0: begin ma = 32'(cy2_q); mb = 32'(cp_q); end
      2'd1: begin ma = 32'(sy_q);  mb = 32'(cp_q); end
      2'd2: begin ma = 32'(cy2_q); mb = 32'(sp_q); end
      default: begin ma = 32'(sy_q); mb = 32'(sp_q); end
    endcase
  end
  // operands are within +-2^30 so 32 bits hold them
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mi_q <= '0;
    else if (cmd_i.mul) mi_q <= mi_q + 2'd1;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) pr_q[mi_q] <= 66'(ma * mb);
  end

  assign sts_o.rot_last  = (it_q == 4'(CordicN - 1));
  assign sts_o.sel_pitch = sel_q;
  assign sts_o.mul_last  = (mi_q == 2'd3);

  function automatic logic signed [15:0] q30(input logic signed [33:0] v);
    logic signed [34:0] t;
    logic signed [18:0] r;
    t = 35'(v) + 35'sd32768;
    r = 19'(t >>> 16);
    if (r > 19'sd16384) r = 19'sd16384;
    if (r < -19'sd16384) r = -19'sd16384;
    return 16'(r);
  endfunction

  function automatic logic signed [15:0] q60(input logic signed [65:0] v);
    logic signed [66:0] t;
    logic signed [20:0] r;
    t = 67'(v) + (67'sd1 <<< 45);
    r = 21'(t >>> 46);
    if (r > 21'sd16384) r = 21'sd16384;
    if (r < -21'sd16384) r = -21'sd16384;
    return 16'(r);
  endfunction

  logic deg, pos;
  assign deg = (rp_q == 17'(AngQuart)) || (rp_q == -17'(AngQuart));
  assign pos = (rp_q > -17'(AngQuart)) && (rp_q < 17'(AngQuart));

  always_ff @(posedge clk_i) begin
    if (cmd_i.pack) begin
      front_x_o    <= q60(pr_q[0]);
      front_y_o    <= q30(sp_q);
      front_z_o    <= q60(pr_q[1]);
      yaw_out_o    <= yaw_q[16:0];
      pitch_out_o  <= pitch_q;
      degenerate_o <= deg;
      right_y_o    <= '0;
      if (deg) begin
        right_x_o <= '0;
        right_z_o <= '0;
        up_x_o    <= '0;
        up_y_o    <= '0;
        up_z_o    <= '0;
      end else if (pos) begin
        right_x_o <= q30(-sy_q);
        right_z_o <= q30(cy2_q);
        up_x_o    <= q60(-pr_q[2]);
        up_y_o    <= q30(cp_q);
        up_z_o    <= q60(-pr_q[3]);
      end else begin
        right_x_o <= q30(sy_q);
        right_z_o <= q30(-cy2_q);
        up_x_o    <= q60(pr_q[2]);
        up_y_o    <= q30(-cp_q);
        up_z_o    <= q60(pr_q[3]);
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/euler_camera_orientation_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// euler_camera_orientation_unit: first-person camera basis
// Updates yaw/pitch from mouse deltas and outputs front, right, up vectors.
// ----------------------------------------------------------------------------
// One item at a time: an accepted item has its angles wrapped, then takes
// two 16-iteration CORDIC runs on one shared rotator with a load step each,
// four steps on the shared multiplier and an output step; the next item is
// taken once the previous result is registered. The result register lets
// the next item start while a result waits. Write the sensitivity register
// via cfg_we_i/cfg_wdata_i only while idle; the block does not enforce it.
module euler_camera_orientation_unit import eco_pkg::*; (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire         [15:0] cfg_wdata_i,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire  signed [15:0] delta_x_i,
  input  wire  signed [15:0] delta_y_i,
  input  wire                limit_pitch_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic signed [15:0] front_x_o,
  output logic signed [15:0] front_y_o,
  output logic signed [15:0] front_z_o,
  output logic signed [15:0] right_x_o,
  output logic signed [15:0] right_y_o,
  output logic signed [15:0] right_z_o,
  output logic signed [15:0] up_x_o,
  output logic signed [15:0] up_y_o,
  output logic signed [15:0] up_z_o,
  output logic signed [16:0] yaw_out_o,
  output logic signed [23:0] pitch_out_o,
  output logic               degenerate_o
);

  cmd_t cmd;
  sts_t sts;

  eco_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  eco_dp u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .delta_x_i, .delta_y_i,
    .limit_pitch_i, .cmd_i(cmd), .sts_o(sts),
    .front_x_o, .front_y_o, .front_z_o, .right_x_o, .right_y_o, .right_z_o,
    .up_x_o, .up_y_o, .up_z_o, .yaw_out_o, .pitch_out_o, .degenerate_o
  );

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: camera orientation unit check
// Drives mouse delta items through valid/ready with random gaps and stalls,
// predicts angles and basis vectors with a CORDIC-exact model and compares
// every result field. A short directed table comes first, then random phases.
// ----------------------------------------------------------------------------
module testbench;
  import eco_pkg::*;

  typedef struct {
    logic signed [15:0] fx, fy, fz, rx, ry, rz, ux, uy, uz;
    logic signed [16:0] yaw;
    logic signed [23:0] pitch;
    logic               degen;
  } basis_t;

  typedef struct {
    int  sens;
    int  dx, dy;
    bit  lim;
    bit  ck_yaw, ck_pitch;
    int  e_yaw, e_pitch;
    bit  e_degen;
  } dir_row_t;

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0;
  logic [15:0] cfg_wdata = '0;
  logic in_valid = 0, out_ready = 0;
  logic signed [15:0] dx_in = '0, dy_in = '0;
  logic lim_in = 0;
  logic in_ready, out_valid, degen_o;
  logic signed [15:0] fx_o, fy_o, fz_o, rx_o, ry_o, rz_o, ux_o, uy_o, uz_o;
  logic signed [16:0] yaw_o;
  logic signed [23:0] pitch_o;

  euler_camera_orientation_unit u_dut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .delta_x_i(dx_in), .delta_y_i(dy_in), .limit_pitch_i(lim_in),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .front_x_o(fx_o), .front_y_o(fy_o), .front_z_o(fz_o),
    .right_x_o(rx_o), .right_y_o(ry_o), .right_z_o(rz_o),
    .up_x_o(ux_o), .up_y_o(uy_o), .up_z_o(uz_o),
    .yaw_out_o(yaw_o), .pitch_out_o(pitch_o), .degenerate_o(degen_o)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  // model state
  longint yaw_st, pitch_st, sens_st;
  basis_t expected_q[$];
  int errors = 0;
  int send_idle = 0, recv_idle = 0;
  logic hold_trig = 0;
  int hold_left = 0;
  bit hold_done = 0;
  // next typed override for the directed table
  dir_row_t pend_row;
  bit pend_valid = 0;

  function automatic longint wrap_ang(longint a);
    longint m;
    m = (a + AngHalf) % AngFull;
    if (m < 0) m += AngFull;
    return m - AngHalf;
  endfunction

  function automatic longint clamp14(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  function automatic longint rnd30(longint v);
    return clamp14((v + (longint'(1) << 15)) >>> 16);
  endfunction

  function automatic longint rnd60(longint v);
    return clamp14((v + (longint'(1) << 45)) >>> 46);
  endfunction

  function automatic void cordic_sc(input longint a, output longint sn, output longint cs);
    longint x, y, z, ddx, ddy;
    bit neg;
    neg = 0;
    x = 652032874;
    y = 0;
    if (a == 0) begin sn = 0; cs = 1073741824; return; end
    if (a == AngQuart) begin sn = 1073741824; cs = 0; return; end
    if (a == -AngQuart) begin sn = -1073741824; cs = 0; return; end
    if (a == -AngHalf) begin sn = 0; cs = -1073741824; return; end
    if (a > AngQuart) begin a -= AngHalf; neg = 1; end
    else if (a < -AngQuart) begin a += AngHalf; neg = 1; end
    z = a * 256;
    for (int i = 0; i < CordicN; i++) begin
      ddx = y >>> i;
      ddy = x >>> i;
      if (z >= 0) begin
        x -= ddx; y += ddy; z -= longint'(atan_q16(i[3:0]));
      end else begin
        x += ddx; y -= ddy; z += longint'(atan_q16(i[3:0]));
      end
    end
    sn = neg ? -y : y;
    cs = neg ? -x : x;
  endfunction

  function automatic basis_t predict_basis(logic signed [15:0] ddx,
                                           logic signed [15:0] ddy, logic lim);
    basis_t r;
    longint ix, iy, p, rp, sy, cy, sp, cp, s;
    ix = (longint'(ddx) * sens_st + 128) >>> 8;
    iy = (longint'(ddy) * sens_st + 128) >>> 8;
    yaw_st = wrap_ang(yaw_st + ix);
    p = pitch_st + iy;
    if (p > 8388607) p = 8388607;
    if (p < -8388608) p = -8388608;
    if (lim) begin
      if (p > PitchLim) p = PitchLim;
      if (p < -PitchLim) p = -PitchLim;
    end
    pitch_st = p;
    rp = wrap_ang(p);
    cordic_sc(yaw_st, sy, cy);
    cordic_sc(rp, sp, cp);
    r.fx = 16'(rnd60(cy * cp));
    r.fy = 16'(rnd30(sp));
    r.fz = 16'(rnd60(sy * cp));
    r.yaw = 17'(yaw_st);
    r.pitch = 24'(p);
    if (rp == AngQuart || rp == -AngQuart) begin
      r.rx = '0; r.ry = '0; r.rz = '0; r.ux = '0; r.uy = '0; r.uz = '0;
      r.degen = 1;
    end else begin
      s = (rp > -AngQuart && rp < AngQuart) ? 1 : -1;
      r.rx = 16'(rnd30(-s * sy));
      r.ry = '0;
      r.rz = 16'(rnd30(s * cy));
      r.ux = 16'(rnd60(-s * cy * sp));
      r.uy = 16'(rnd30(s * cp));
      r.uz = 16'(rnd60(-s * sy * sp));
      r.degen = 0;
    end
    return r;
  endfunction

  task automatic chk(string name, longint e, longint a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
      errors++;
    end
  endtask

  // accepted items and results
  always @(posedge clk) begin
    basis_t b;
    if (rst_n && in_valid && in_ready) begin
      b = predict_basis(dx_in, dy_in, lim_in);
      if (pend_valid) begin
        if (pend_row.ck_yaw) b.yaw = 17'(pend_row.e_yaw);
        if (pend_row.ck_pitch) begin
          b.pitch = 24'(pend_row.e_pitch);
          b.degen = pend_row.e_degen;
        end
      end
      expected_q.push_back(b);
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result item with nothing expected", $time);
        errors++;
      end else begin
        b = expected_q.pop_front();
        chk("front_x", b.fx, fx_o); chk("front_y", b.fy, fy_o);
        chk("front_z", b.fz, fz_o); chk("right_x", b.rx, rx_o);
        chk("right_y", b.ry, ry_o); chk("right_z", b.rz, rz_o);
        chk("up_x", b.ux, ux_o); chk("up_y", b.uy, uy_o);
        chk("up_z", b.uz, uz_o); chk("yaw_out", b.yaw, yaw_o);
        chk("pitch_out", b.pitch, pitch_o); chk("degenerate", b.degen, degen_o);
      end
    end
  end

  // receiver with one long hold-off on request
  always @(posedge clk) begin
    if (hold_trig && !hold_done) begin
      hold_done = 1;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_item(int ddx, int ddy, bit lim);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    dx_in <= 16'(ddx);
    dy_in <= 16'(ddy);
    lim_in <= lim;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_sens(int v);
    drain();
    cfg_wdata <= 16'(v);
    cfg_we <= 1;
    @(posedge clk);
    cfg_we <= 0;
    sens_st = longint'(v);
    @(posedge clk);
  endtask

  function automatic int rnd_delta();
    if ($urandom_range(99) < 25) return int'($urandom_range(65535)) - 32768;
    return int'($urandom_range(4000)) - 2000;
  endfunction

  dir_row_t dir_tab[$];

  initial begin
    int sens_plan[6];
    yaw_st = longint'(-AngQuart);
    pitch_st = 0;
    sens_st = longint'(SensReset);
    dir_tab.push_back('{410, 0, 0, 0, 1, 1, -23040, 0, 0});
    dir_tab.push_back('{410, 32767, 32767, 0, 0, 0, 0, 0, 0});
    dir_tab.push_back('{410, -32768, -32768, 1, 0, 0, 0, 0, 0});
    dir_tab.push_back('{410, 1, -1, 0, 0, 0, 0, 0, 0});
    dir_tab.push_back('{4096, 32767, 32767, 1, 0, 1, 0, 22784, 0});
    dir_tab.push_back('{4096, 0, -32768, 1, 0, 1, 0, -22784, 0});
    // straight up, straight down, then upside down
    dir_tab.push_back('{4096, 0, 2864, 0, 0, 1, 0, 23040, 1});
    dir_tab.push_back('{4096, 0, -2880, 0, 0, 1, 0, -23040, 1});
    dir_tab.push_back('{4096, 0, -1440, 0, 0, 1, 0, -46080, 0});
    dir_tab.push_back('{4096, -32768, 0, 0, 0, 0, 0, 0, 0});
    dir_tab.push_back('{4096, 1440, 720, 0, 0, 0, 0, 0, 0});
    dir_tab.push_back('{65535, 32767, 32767, 0, 0, 0, 0, 0, 0});
    dir_tab.push_back('{65535, 32767, 32767, 0, 0, 1, 0, 8388607, 0});
    dir_tab.push_back('{65535, -32768, -32768, 0, 0, 0, 0, 0, 0});
    dir_tab.push_back('{65535, -32768, -32768, 0, 0, 0, 0, 0, 0});
    dir_tab.push_back('{65535, -32768, -32768, 0, 0, 1, 0, -8388608, 0});
    dir_tab.push_back('{0, 12345, -12345, 1, 0, 0, 0, 0, 0});

    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_idle = 34;
    recv_idle = 70;
    for (int i = 0; i < dir_tab.size(); i++) begin
      if (dir_tab[i].sens != sens_st) set_sens(dir_tab[i].sens);
      // override applies to this item only, so keep one in flight
      drain();
      pend_row = dir_tab[i];
      pend_valid = 1;
      send_item(dir_tab[i].dx, dir_tab[i].dy, dir_tab[i].lim);
      in_valid <= 0;
      @(posedge clk);
      pend_valid = 0;
    end

    sens_plan = '{$urandom_range(65535), 0, 65535, 410, $urandom_range(8191), 4096};
    for (int ph = 0; ph < 6; ph++) begin
      set_sens(sens_plan[ph]);
      case (ph / 2)
        0: begin send_idle = 34; recv_idle = 70; end
        1: begin send_idle = 70; recv_idle = 34; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      if (ph == 4) hold_trig <= 1;
      for (int n = 0; n < 205; n++)
        send_item(rnd_delta(), rnd_delta(), 1'($urandom_range(1)));
    end

    drain();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/eco_pkg.sv
design/eco_ctrl.sv
design/eco_dp.sv
design/euler_camera_orientation_unit.sv
tb/sv/testbench.sv
